// ----- design/oal_pkg.sv -----
// ----------------------------------------------------------------------------
// oal_pkg: shared definitions of the ordered array list engine
// Field widths, command and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package oal_pkg;

	// default list depth
	localparam int SIZE_DEF = 8;

	// word field widths
	localparam int CMD_W   = 3;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 4;
	localparam int ST_W    = 3;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd6;

	// status codes
	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [ST_W-1:0] ST_OOB      = 3'd3;
	localparam logic [ST_W-1:0] ST_FOUND    = 3'd4;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd5;

	// what one cell does on the next edge
	typedef struct packed {
		logic load_value;  // take the new word value
		logic shift_up;    // take the entry of the cell below
		logic shift_down;  // take the entry of the cell above
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/oal_cmd_if.sv -----
// ----------------------------------------------------------------------------
// oal_cmd_if: command channel of the ordered array list engine
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface oal_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [oal_pkg::CMD_W-1:0]          command;
	logic signed [oal_pkg::VALUE_W-1:0] value;
	logic [oal_pkg::POS_W-1:0]          position;

	modport source (output valid, command, value, position, input ready);
	modport sink   (input valid, command, value, position, output ready);
endinterface

`default_nettype wire

// ----- design/oal_res_if.sv -----
// ----------------------------------------------------------------------------
// oal_res_if: result channel of the ordered array list engine
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface oal_res_if;
	logic                      valid;
	logic                      ready;
	logic [oal_pkg::ST_W-1:0]  status;
	logic [oal_pkg::POS_W-1:0] found_position;
	logic [oal_pkg::POS_W-1:0] count;

	modport source (output valid, status, found_position, count, input ready);
	modport sink   (input valid, status, found_position, count, output ready);
endinterface

`default_nettype wire

// ----- design/oal_cell.sv -----
// ----------------------------------------------------------------------------
// oal_cell: one slot of the list
// Holds one entry, loads from its neighbors or the new value, and compares
// its entry against the search value.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire oal_pkg::cell_ctl_t          ctl,
	input  wire logic [oal_pkg::VALUE_W-1:0] value,
	input  wire logic [oal_pkg::VALUE_W-1:0] below,
	input  wire logic [oal_pkg::VALUE_W-1:0] above,
	input  wire logic                        in_use,
	output logic      [oal_pkg::VALUE_W-1:0] entry,
	output logic                             match
);

	logic [oal_pkg::VALUE_W-1:0] entry_q;

	// slot storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.load_value) begin
			entry_q <= value;
		end else if (ctl.shift_up) begin
			entry_q <= below;
		end else if (ctl.shift_down) begin
			entry_q <= above;
		end
	end

	assign entry = entry_q;
	// only stored entries count as hits
	assign match = in_use && (entry_q == value);

endmodule

`default_nettype wire

// ----- design/oal_find.sv -----
// ----------------------------------------------------------------------------
// oal_find: first-match encoder
// Turns the registered match vector into the 1-based position of the
// lowest set bit, zero when no bit is set.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_find #(
	parameter int N  = oal_pkg::SIZE_DEF,
	parameter int OW = 4
) (
	input  wire logic [N-1:0]  match,
	output logic               hit,
	output logic      [OW-1:0] pos
);

	// scan from the top so the lowest match wins
	always_comb begin
		pos = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (match[i]) begin
				pos = OW'(i + 1);
			end
		end
	end

	assign hit = |match;

endmodule

`default_nettype wire

// ----- design/ordered_array_list_engine.sv -----
// ----------------------------------------------------------------------------
// ordered_array_list_engine: ordered list of signed 32-bit values
// A row of cells holds the list; inserts and deletes shift its cells in parallel.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  (sink):   one command word per handshake: command, value, position.
//   res  (source): one result word per command: status, found_position,
//                  count (entries after the command).
//   Each command updates the cell row at the edge it is accepted; all cells
//   shift or load at that edge and compare against the value in
//   parallel. The match vector is registered and encoded to a position in a
//   second stage, the result register, which drives the res word.
//   Throughput is one command per cycle unless a held result stalls cmd;
//   the cell row, the fill count and both pipeline stages hold the state.
//   Reset clears the list, the count and the valid flags of both pipeline stages.
//   When the receiver holds res.ready low, the result register and then the
//   middle stage hold their words; cmd.ready drops once both are full and
//   returns as soon as the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_list_engine #(
	parameter int SIZE = oal_pkg::SIZE_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	oal_cmd_if.sink   cmd,
	oal_res_if.source res
);

	localparam int CW   = $clog2(SIZE + 1);
	localparam int CMPW = (CW > oal_pkg::POS_W) ? CW : oal_pkg::POS_W;

	// list state
	logic [CW-1:0] fill_q;

	// stage 1
	logic                       s1_valid_q;
	logic [oal_pkg::ST_W-1:0]   status_s1;
	logic                       search_s1;
	logic [SIZE-1:0]            match_s1;
	logic [CMPW-1:0]            count_s1;

	// result register
	logic                        res_valid_q;
	logic [oal_pkg::ST_W-1:0]    res_status_q;
	logic [oal_pkg::POS_W-1:0]   res_found_q;
	logic [oal_pkg::POS_W-1:0]   res_count_q;

	// handshake
	logic advance;
	logic accept;

	assign advance   = !res_valid_q || res.ready;
	assign cmd.ready = !s1_valid_q || advance;
	assign accept    = cmd.valid && cmd.ready;

	// command decode
	logic [CMPW-1:0]          fill_x;
	logic [CMPW-1:0]          pos_x;
	logic                     full;
	logic                     empty;
	logic                     pos_bad;
	logic [oal_pkg::ST_W-1:0] st;
	logic                     do_ins;
	logic                     do_del;
	logic                     do_srch;
	logic [CMPW-1:0]          slot;
	logic [CMPW-1:0]          fill_next;

	assign fill_x  = CMPW'(fill_q);
	assign pos_x   = CMPW'(cmd.position);
	assign full    = fill_x == CMPW'(SIZE);
	assign empty   = fill_x == '0;
	assign pos_bad = (pos_x == '0) || (pos_x > fill_x);

	always_comb begin
		st      = oal_pkg::ST_OK;
		do_ins  = 1'b0;
		do_del  = 1'b0;
		do_srch = 1'b0;
		slot    = '0;
		case (cmd.command)
			oal_pkg::CMD_INS_FRONT: begin
				if (full) st = oal_pkg::ST_OVERFLOW;
				else do_ins = 1'b1;
			end
			oal_pkg::CMD_INS_POS: begin
				if (full) begin
					st = oal_pkg::ST_OVERFLOW;
				end else if (empty) begin
					do_ins = 1'b1;
				end else if (pos_bad) begin
					st = oal_pkg::ST_OOB;
				end else begin
					do_ins = 1'b1;
					slot   = pos_x - CMPW'(1);
				end
			end
			oal_pkg::CMD_INS_BACK: begin
				if (full) begin
					st = oal_pkg::ST_OVERFLOW;
				end else begin
					do_ins = 1'b1;
					slot   = fill_x;
				end
			end
			oal_pkg::CMD_DEL_FRONT: begin
				if (empty) st = oal_pkg::ST_EMPTY;
				else do_del = 1'b1;
			end
			oal_pkg::CMD_DEL_POS: begin
				if (empty) begin
					st = oal_pkg::ST_EMPTY;
				end else if (pos_bad) begin
					st = oal_pkg::ST_OOB;
				end else begin
					do_del = 1'b1;
					slot   = pos_x - CMPW'(1);
				end
			end
			oal_pkg::CMD_DEL_BACK: begin
				if (empty) begin
					st = oal_pkg::ST_EMPTY;
				end else begin
					do_del = 1'b1;
					slot   = fill_x - CMPW'(1);
				end
			end
			oal_pkg::CMD_SEARCH: begin
				if (empty) st = oal_pkg::ST_EMPTY;
				else do_srch = 1'b1;
			end
			default: begin
				st = oal_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		fill_next = fill_x;
		if (do_ins) fill_next = fill_x + CMPW'(1);
		else if (do_del) fill_next = fill_x - CMPW'(1);
	end

	// cell row
	logic [oal_pkg::VALUE_W-1:0] ent [SIZE];
	logic [SIZE-1:0]             match;

	for (genvar i = 0; i < SIZE; i++) begin : g_cell
		oal_pkg::cell_ctl_t          ctl;
		logic [oal_pkg::VALUE_W-1:0] below;
		logic [oal_pkg::VALUE_W-1:0] above;
		logic                        in_use;

		always_comb begin
			ctl.load_value = accept && do_ins && (CMPW'(i) == slot);
			ctl.shift_up   = accept && do_ins && (CMPW'(i) > slot);
			ctl.shift_down = accept && do_del && (CMPW'(i) >= slot);
		end

		assign in_use = CMPW'(i) < fill_x;

		if (i == 0) begin : g_bot
			assign below = '0;
		end else begin : g_mid
			assign below = ent[i-1];
		end

		if (i == SIZE - 1) begin : g_top
			assign above = '0;
		end else begin : g_low
			assign above = ent[i+1];
		end

		oal_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.value  (cmd.value),
			.below  (below),
			.above  (above),
			.in_use (in_use),
			.entry  (ent[i]),
			.match  (match[i])
		);
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= CW'(fill_next);
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= st;
			search_s1 <= do_srch;
			match_s1  <= match;
			count_s1  <= fill_next;
		end
	end

	// first-match encode
	logic            hit;
	logic [CMPW-1:0] hit_pos;

	oal_find #(
		.N  (SIZE),
		.OW (CMPW)
	) u_find (
		.match (match_s1),
		.hit   (hit),
		.pos   (hit_pos)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q) begin
			res_count_q <= count_s1[oal_pkg::POS_W-1:0];
			if (search_s1) begin
				res_status_q <= hit ? oal_pkg::ST_FOUND : oal_pkg::ST_NOTFOUND;
				res_found_q  <= hit ? hit_pos[oal_pkg::POS_W-1:0] : '0;
			end else begin
				res_status_q <= status_s1;
				res_found_q  <= '0;
			end
		end
	end

	assign res.valid          = res_valid_q;
	assign res.status         = res_status_q;
	assign res.found_position = res_found_q;
	assign res.count          = res_count_q;

`ifndef ASSERT_OFF
	// count never exceeds the depth
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(fill_q) <= CMPW'(SIZE))
		else $error("fill count beyond list depth");

	// a stalled result keeps the middle stage loaded
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && res_valid_q && !res.ready |=> s1_valid_q)
		else $error("middle stage lost its word under stall");

	// a full list refuses inserts and keeps its count
	a_full_ins: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && (cmd.command == oal_pkg::CMD_INS_FRONT ||
		cmd.command == oal_pkg::CMD_INS_POS ||
		cmd.command == oal_pkg::CMD_INS_BACK) |=> fill_q == $past(fill_q))
		else $error("insert into full list changed the count");

	// a found result points inside the list
	a_found_pos: assert property (@(posedge clk) disable iff (!arst_n)
		search_s1 && s1_valid_q && hit |-> hit_pos != '0 && hit_pos <= count_s1)
		else $error("search hit outside the stored entries");
`endif

endmodule

`default_nettype wire
